FILE: rtl/core/mlt_pkg.sv
// Shared types and constants for the Manchester line transmitter.
package mlt_pkg;

  localparam int KindW      = 2;
  localparam int ChW        = 2;
  localparam int SlotW      = 4;
  localparam int ByteW      = 8;
  localparam int LenW       = 5;
  localparam int CntW       = 4;
  localparam int HalfBits   = 16;
  localparam int DataBits   = 8;
  localparam int WordW      = HalfBits;

  localparam int CHANNELS_DEF  = 4;
  localparam int MAX_WORDS_DEF = 16;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ChW-1:0]   channel;
    logic [SlotW-1:0] slot;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  length;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] out_channel;
    logic           line_level;
    logic           finished;
    logic           busy_res;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [LenW-1:0] pos;
    logic [LenW-1:0] msg;
  } chan_state_t;

  typedef struct packed {
    logic            valid;
    logic            start;
    logic [ChW-1:0]  ch;
    logic [LenW-1:0] len;
  } chan_req_t;

  typedef struct packed {
    logic            valid;
    logic [ChW-1:0]  ch;
    logic            fin;
    logic [CntW-1:0] cnt;
  } tick_res_t;

  typedef struct packed {
    logic             en;
    logic [ChW-1:0]   ch;
    logic [SlotW-1:0] slot;
    logic [ByteW-1:0] data;
  } word_wr_t;

  typedef struct packed {
    logic            en;
    logic [ChW-1:0]  ch;
    logic [LenW-1:0] pos;
  } word_rd_t;

endpackage

FILE: rtl/core/mlt_word_store.sv
// Encoded word buffer: one write and one registered read per cycle.
module mlt_word_store #(
  parameter int CHANNELS  = mlt_pkg::CHANNELS_DEF,
  parameter int MAX_WORDS = mlt_pkg::MAX_WORDS_DEF
) (
  input  logic                     clk_i,
  input  mlt_pkg::word_wr_t        wr_i,
  input  mlt_pkg::word_rd_t        rd_i,
  output logic [mlt_pkg::WordW-1:0] rd_word_o
);
  import mlt_pkg::*;

  localparam int Depth = CHANNELS * MAX_WORDS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  function automatic logic [WordW-1:0] encode(input logic [ByteW-1:0] b);
    logic [WordW-1:0] w;
    w = '0;
    for (int j = 0; j < DataBits; j++) begin
      w[2*j]   = b[j];
      w[2*j+1] = ~b[j];
    end
    return w;
  endfunction

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rd_word_q;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  assign wr_addr = AddrW'(32'(wr_i.ch) * MAX_WORDS + 32'(wr_i.slot));
  assign rd_addr = AddrW'(32'(rd_i.ch) * MAX_WORDS + 32'(rd_i.pos));

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= encode(wr_i.data);
    end
    if (rd_i.en) begin
      rd_word_q <= mem[rd_addr];
    end
  end

  assign rd_word_o = rd_word_q;

endmodule

FILE: rtl/core/mlt_chan_ctrl.sv
// Per-channel state memory with read-modify-write and write-back forwarding.
module mlt_chan_ctrl #(
  parameter int CHANNELS  = mlt_pkg::CHANNELS_DEF,
  parameter int MAX_WORDS = mlt_pkg::MAX_WORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlt_pkg::chan_req_t req_i,
  input  logic               s3_free_i,
  output logic               s2_free_o,
  output mlt_pkg::tick_res_t tick_o,
  output mlt_pkg::word_rd_t  word_rd_o
);
  import mlt_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chan_state_t     mem [CHANNELS];
  logic [CHANNELS-1:0] vld_q;

  logic            s2_valid_q;
  logic            s2_start_q;
  logic [ChW-1:0]  s2_ch_q;
  logic [LenW-1:0] s2_len_q;
  chan_state_t     st_q;

  chan_state_t     st_d;
  logic            fin;
  logic            s2_adv;
  logic [LenW-1:0] len_sat;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;

  assign rd_idx  = IdxW'(req_i.ch);
  assign wr_idx  = IdxW'(s2_ch_q);
  assign len_sat = (32'(req_i.len) > 32'(MAX_WORDS)) ? LenW'(MAX_WORDS) : req_i.len;

  assign fin       = (st_q.pos == st_q.msg);
  assign s2_adv    = s2_valid_q && (s2_start_q || s3_free_i);
  assign s2_free_o = !s2_valid_q || s2_adv;

  always_comb begin
    st_d = st_q;
    if (s2_start_q) begin
      st_d.cnt = '0;
      st_d.pos = '0;
      st_d.msg = s2_len_q;
    end else if (!fin) begin
      st_d.cnt = st_q.cnt + CntW'(1);
      if (st_q.cnt == CntW'(HalfBits - 1)) begin
        st_d.pos = st_q.pos + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      if (req_i.valid) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      mem[wr_idx] <= st_d;
    end
    if (req_i.valid) begin
      s2_start_q <= req_i.start;
      s2_ch_q    <= req_i.ch;
      s2_len_q   <= len_sat;
      if (s2_adv && (s2_ch_q == req_i.ch)) begin
        st_q <= st_d;
      end else if (vld_q[rd_idx]) begin
        st_q <= mem[rd_idx];
      end else begin
        st_q <= '0;
      end
    end
  end

  assign tick_o.valid = s2_adv && !s2_start_q;
  assign tick_o.ch    = s2_ch_q;
  assign tick_o.fin   = fin;
  assign tick_o.cnt   = st_q.cnt;

  assign word_rd_o.en  = s2_adv && !s2_start_q && !fin;
  assign word_rd_o.ch  = s2_ch_q;
  assign word_rd_o.pos = st_q.pos;

endmodule

FILE: rtl/core/manchester_line_transmitter.sv
// Manchester line transmitter top level: pipeline control and result register.
//
// One input channel (in_valid_i / in_stall_o / in_item_i) carries load, start and
// tick transactions; one output channel (out_valid_o / out_stall_i / out_item_o)
// returns one result per tick on an existing channel. Loads, starts, kind 3 and
// channels at or above CHANNELS give no result.
// A tick's channel state is read at its acceptance edge, then its word is read,
// then the result register is loaded. Throughput: one transaction per cycle of
// any kind while out_stall_i does not hold, set by the single read-modify-write port
// of the channel state memory and the single read port of the word buffer.
// Reset clears the channel counters at once through per-entry valid bits; the
// word buffer is not cleared, and a tick must only read slots loaded since reset.
// When out_stall_i holds, the result register keeps its transaction and the
// pipeline behind it keeps filling; in_stall_o rises once the state stage is
// occupied and cannot move on.
module manchester_line_transmitter #(
  parameter int CHANNELS  = mlt_pkg::CHANNELS_DEF,
  parameter int MAX_WORDS = mlt_pkg::MAX_WORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mlt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mlt_pkg::out_item_t out_item_o
);
  import mlt_pkg::*;

  logic            accept;
  logic            ch_ok;
  logic            s2_free;
  logic            s3_free;
  logic            s3_adv;
  logic            out_free;
  chan_req_t       req;
  tick_res_t       tick;
  word_wr_t        word_wr;
  word_rd_t        word_rd;
  logic [WordW-1:0] rd_word;

  logic            s3_valid_q;
  logic [ChW-1:0]  s3_ch_q;
  logic            s3_fin_q;
  logic [CntW-1:0] s3_cnt_q;

  logic            out_valid_q;
  out_item_t       out_q;

  assign in_stall_o = !s2_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign ch_ok      = 32'(in_item_i.channel) < 32'(CHANNELS);

  assign req.valid = accept && ch_ok &&
                     ((in_item_i.kind == KIND_START) || (in_item_i.kind == KIND_TICK));
  assign req.start = (in_item_i.kind == KIND_START);
  assign req.ch    = in_item_i.channel;
  assign req.len   = in_item_i.length;

  assign word_wr.en   = accept && ch_ok && (in_item_i.kind == KIND_LOAD) &&
                        (32'(in_item_i.slot) < 32'(MAX_WORDS));
  assign word_wr.ch   = in_item_i.channel;
  assign word_wr.slot = in_item_i.slot;
  assign word_wr.data = in_item_i.data_byte;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s3_adv   = s3_valid_q && out_free;
  assign s3_free  = !s3_valid_q || out_free;

  mlt_chan_ctrl #(
    .CHANNELS  (CHANNELS),
    .MAX_WORDS (MAX_WORDS)
  ) u_chan_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .s3_free_i (s3_free),
    .s2_free_o (s2_free),
    .tick_o    (tick),
    .word_rd_o (word_rd)
  );

  mlt_word_store #(
    .CHANNELS  (CHANNELS),
    .MAX_WORDS (MAX_WORDS)
  ) u_word_store (
    .clk_i     (clk_i),
    .wr_i      (word_wr),
    .rd_i      (word_rd),
    .rd_word_o (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick.valid) begin
        s3_valid_q <= 1'b1;
      end else if (s3_adv) begin
        s3_valid_q <= 1'b0;
      end
      if (s3_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick.valid) begin
      s3_ch_q  <= tick.ch;
      s3_fin_q <= tick.fin;
      s3_cnt_q <= tick.cnt;
    end
    if (s3_adv) begin
      out_q.out_channel <= s3_ch_q;
      out_q.line_level  <= s3_fin_q ? 1'b0 : rd_word[s3_cnt_q];
      out_q.finished    <= s3_fin_q;
      out_q.busy_res    <= !s3_fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_tick_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick.valid |-> s3_free)
    else $error("tick leaves state stage while word stage is blocked");

  a_word_read_only_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_rd.en |-> (tick.valid && !tick.fin))
    else $error("word buffer read outside a live tick");

  a_finish_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.finished) |-> (!out_item_o.busy_res && !out_item_o.line_level))
    else $error("completion result shows busy or a high line");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the Manchester line transmitter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlt_pkg::*;

  localparam int NumCh      = CHANNELS_DEF;
  localparam int NumWords   = MAX_WORDS_DEF;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 20;
  localparam int ItemsPerPhase = 60;
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  class line_scoreboard;
    bit [WordW-1:0] words [NumCh][NumWords];
    bit             loaded [NumCh][NumWords];
    bit [CntW-1:0]  half_cnt [NumCh];
    bit [LenW-1:0]  word_pos [NumCh];
    bit [LenW-1:0]  msg_words [NumCh];
    bit             sending [NumCh];
    out_item_t      expected_q [$];
    int errors, results, loads, starts, ticks, completions;

    function bit [WordW-1:0] encode(bit [ByteW-1:0] b);
      bit [WordW-1:0] w;
      for (int j = 0; j < DataBits; j++) begin
        w[2*j]   = b[j];
        w[2*j+1] = ~b[j];
      end
      return w;
    endfunction

    // Slot the next tick on this channel would read, if it has never been loaded.
    function bit needs_load(int ch, output int slot);
      slot = int'(word_pos[ch]);
      return word_pos[ch] != msg_words[ch] && word_pos[ch] < NumWords &&
             !loaded[ch][word_pos[ch]];
    endfunction

    function void note_input(in_item_t it);
      int c;
      out_item_t e;
      c = int'(it.channel);
      if (c >= NumCh) return;
      case (it.kind)
        KIND_LOAD: begin
          loads++;
          if (it.slot < NumWords) begin
            words[c][it.slot]  = encode(it.data_byte);
            loaded[c][it.slot] = 1'b1;
          end
        end
        KIND_START: begin
          starts++;
          msg_words[c] = (it.length > NumWords) ? LenW'(NumWords) : it.length;
          word_pos[c]  = '0;
          half_cnt[c]  = '0;
          sending[c]   = 1'b1;
        end
        KIND_TICK: begin
          ticks++;
          e.out_channel = it.channel;
          if (word_pos[c] != msg_words[c]) begin
            e.line_level = (word_pos[c] < NumWords) ?
                           words[c][word_pos[c]][half_cnt[c]] : 1'b0;
            e.finished   = 1'b0;
            e.busy_res   = sending[c];
            half_cnt[c]++;
            if (half_cnt[c] == 0) word_pos[c]++;
          end else begin
            sending[c]   = 1'b0;
            e.line_level = 1'b0;
            e.finished   = 1'b1;
            e.busy_res   = 1'b0;
            completions++;
          end
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void mismatch(string field, int exp_v, int act_v);
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      e = expected_q.pop_front();
      if (got.out_channel !== e.out_channel)
        mismatch("out_channel", int'(e.out_channel), int'(got.out_channel));
      if (got.line_level !== e.line_level)
        mismatch("line_level", int'(e.line_level), int'(got.line_level));
      if (got.finished !== e.finished)
        mismatch("finished", int'(e.finished), int'(got.finished));
      if (got.busy_res !== e.busy_res)
        mismatch("busy_res", int'(e.busy_res), int'(got.busy_res));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  line_scoreboard sb = new();
  int in_idle_pct  = 0;
  int out_stall_pct = 0;
  int sent = 0;
  int cycles = 0;

  manchester_line_transmitter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_item_t mk(logic [KindW-1:0] kind, int ch, int slot, int data, int len);
    in_item_t it;
    it.kind      = kind;
    it.channel   = ChW'(ch);
    it.slot      = SlotW'(slot);
    it.data_byte = ByteW'(data);
    it.length    = LenW'(len);
    return it;
  endfunction

  function automatic int pick_length();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
  endfunction

  function automatic in_item_t rand_item();
    int r;
    in_item_t it;
    r = $urandom_range(0, 99);
    it = mk(KIND_TICK, $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 255),
            $urandom_range(0, 31));
    if (r < 25) it.kind = KIND_LOAD;
    else if (r < 40) begin
      it.kind   = KIND_START;
      it.length = LenW'(pick_length());
    end else if (r < 50) it.kind = KindUnused;
    return it;
  endfunction

  // Entered and left at a falling edge; valid stays up until the next transaction or idle.
  task automatic send(in_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Never let a tick read a slot that was not loaded: load it instead.
  task automatic issue(in_item_t it);
    int slot;
    if (it.kind == KIND_TICK && sb.needs_load(int'(it.channel), slot)) begin
      it.kind      = KIND_LOAD;
      it.slot      = SlotW'(slot);
      it.data_byte = ByteW'($urandom_range(0, 255));
    end
    if (it.kind != KindUnused) sent++;
    send(it);
  endtask

  task automatic message(int ch);
    int len, n;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
    n = (len > NumWords) ? NumWords : len;
    for (int s = 0; s < n; s++)
      issue(mk(KIND_LOAD, ch, s, $urandom_range(0, 255), $urandom_range(0, 31)));
    issue(mk(KIND_START, ch, $urandom_range(0, 15), $urandom_range(0, 255), len));
    for (int t = 0; t <= HalfBits * n; t++) begin
      if ($urandom_range(0, 7) == 0) issue(rand_item());
      issue(mk(KIND_TICK, ch, $urandom_range(0, 15), $urandom_range(0, 255),
               $urandom_range(0, 31)));
    end
  endtask

  task automatic run_directed();
    issue(mk(KIND_TICK, 0, 0, 0, 0));
    issue(mk(KindUnused, 1, 15, 255, 31));
    issue(mk(KIND_LOAD, 0, 0, 8'hFF, 0));
    issue(mk(KIND_LOAD, 0, 1, 8'h00, 31));
    issue(mk(KIND_LOAD, 2, 15, 8'h81, 0));
    issue(mk(KIND_START, 1, 0, 0, 0));
    issue(mk(KIND_TICK, 1, 0, 0, 0));
    issue(mk(KIND_TICK, 1, 0, 0, 0));
    issue(mk(KIND_START, 2, 0, 0, 31));
    issue(mk(KIND_START, 0, 0, 0, 2));
    repeat (2) issue(mk(KIND_TICK, 0, 0, 0, 0));
    issue(mk(KIND_START, 0, 0, 0, 1));
    repeat (17) issue(mk(KIND_TICK, 0, 0, 0, 0));
  endtask

  initial begin
    int target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 75; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 75; end
        default: begin in_idle_pct = 32; out_stall_pct = 32; end
      endcase
      target = sent + ItemsPerPhase;
      while (sent < target) begin
        if ($urandom_range(0, 3) != 0) message($urandom_range(0, NumCh - 1));
        else repeat (8) issue(rand_item());
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("tb: %0d transactions (%0d loads, %0d starts, %0d ticks) over four idle/stall mixes",
             sent, sb.loads, sb.starts, sb.ticks);
    $display("tb: %0d results checked, %0d completions, %0d mismatches",
             sb.results, sb.completions, sb.errors);
    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
